// ===== sv/ixh_pkg.sv =====
// Types and constants shared by the indexed max-heap modules.
`timescale 1ns / 1ps
package ixh_pkg;

  localparam int ValueW     = 32;
  localparam int LabelW     = 7;
  localparam int LabelCount = 65;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StAbsent = 2'd2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_RM,
    S_UP,
    S_UP_CMP,
    S_DOWN,
    S_DN_CMP,
    S_WRITE,
    S_RD_ROOT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                     op;
    logic signed [ValueW-1:0] value;
    logic [LabelW-1:0]        label;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] max_value;
    logic [LabelW-1:0]        max_label;
    logic signed [ValueW-1:0] removed_value;
    logic                     is_empty;
    logic                     is_full;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [LabelW-1:0]        label;
  } slot_t;

endpackage

// ===== sv/ixh_slot_ram.sv =====
// Heap slot memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module ixh_slot_ram #(
  parameter int Depth = 65,
  parameter int AddrW = 7
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  ixh_pkg::slot_t      wdata_i,
  input  logic [AddrW-1:0]    raddr_a_i,
  input  logic [AddrW-1:0]    raddr_b_i,
  output ixh_pkg::slot_t      rdata_a_o,
  output ixh_pkg::slot_t      rdata_b_o
);

  ixh_pkg::slot_t mem [Depth];
  ixh_pkg::slot_t rdata_a_q;
  ixh_pkg::slot_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/ixh_ctrl.sv =====
// Heap sequencer: label lookup, percolation walk and result assembly.
`timescale 1ns / 1ps
module ixh_ctrl #(
  parameter int Capacity = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ixh_pkg::in_t  in_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ixh_pkg::out_t res_o
);

  localparam int IW = $clog2(Capacity + 1);

  ixh_pkg::state_e state_q, state_d;

  logic signed [ixh_pkg::ValueW-1:0] val_q, val_d;
  logic signed [ixh_pkg::ValueW-1:0] rem_q, rem_d;
  logic [ixh_pkg::LabelW-1:0]        lab_q, lab_d;
  logic [IW-1:0]                     h_q, h_d;
  logic [IW-1:0]                     cnt_q, cnt_d;
  logic [1:0]                        status_q, status_d;
  logic                              down_q, down_d;
  logic                              moved_q, moved_d;
  logic                              present_q [ixh_pkg::LabelCount];
  logic                              pres_we;
  logic                              pres_val;
  logic [ixh_pkg::LabelW-1:0]        pres_addr;

  logic [IW-1:0]                     pos_mem [ixh_pkg::LabelCount];
  logic [IW-1:0]                     pos_rd_q;
  logic                              pos_we;
  logic [ixh_pkg::LabelW-1:0]        pos_waddr;
  logic [IW-1:0]                     pos_wdata;

  logic                              slot_we;
  logic [IW-1:0]                     slot_waddr;
  ixh_pkg::slot_t                    slot_wdata;
  logic [IW-1:0]                     raddr_a, raddr_b;
  ixh_pkg::slot_t                    rd_a, rd_b;

  logic                              accept;
  logic                              lab_ok;
  logic                              lab_present;
  logic [IW:0]                       child_l;
  logic [IW:0]                       child_r;
  logic                              has_child;
  logic                              take_right;
  ixh_pkg::slot_t                    child;
  logic [IW-1:0]                     child_idx;

  assign accept      = in_valid_i && in_ready_o;
  assign lab_ok      = in_i.label < ixh_pkg::LabelW'(ixh_pkg::LabelCount);
  assign lab_present = lab_ok ? present_q[in_i.label] : 1'b0;
  assign child_l     = {h_q, 1'b0};
  assign child_r     = {h_q, 1'b1};
  assign has_child   = child_l <= {1'b0, cnt_q};
  assign take_right  = (child_l != {1'b0, cnt_q}) && (rd_b.value > rd_a.value);
  assign child       = take_right ? rd_b : rd_a;
  assign child_idx   = take_right ? child_r[IW-1:0] : child_l[IW-1:0];

  ixh_slot_ram #(
    .Depth(Capacity + 1),
    .AddrW(IW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (slot_we),
    .waddr_i   (slot_waddr),
    .wdata_i   (slot_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_q <= pos_mem[in_i.label[ixh_pkg::LabelW-1:0]];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ixh_pkg::S_IDLE: begin
        if (accept) begin
          if (!lab_ok) begin
            state_d = ixh_pkg::S_RD_ROOT;
          end else if (lab_present) begin
            state_d = ixh_pkg::S_POS;
          end else if (in_i.op == ixh_pkg::OpRemove ||
                       cnt_q == IW'(Capacity)) begin
            state_d = ixh_pkg::S_RD_ROOT;
          end else begin
            state_d = ixh_pkg::S_UP;
          end
        end
      end
      ixh_pkg::S_POS: begin
        state_d = down_q ? ixh_pkg::S_UP : ixh_pkg::S_RM;
      end
      ixh_pkg::S_RM: begin
        state_d = (h_q != cnt_q) ? ixh_pkg::S_UP : ixh_pkg::S_RD_ROOT;
      end
      ixh_pkg::S_UP: begin
        state_d = (h_q > IW'(1)) ? ixh_pkg::S_UP_CMP : ixh_pkg::S_WRITE;
        if (h_q <= IW'(1) && down_q && !moved_q) begin
          state_d = ixh_pkg::S_DOWN;
        end
      end
      ixh_pkg::S_UP_CMP: begin
        if (val_q > rd_a.value) begin
          state_d = ixh_pkg::S_UP;
        end else if (down_q && !moved_q) begin
          state_d = ixh_pkg::S_DOWN;
        end else begin
          state_d = ixh_pkg::S_WRITE;
        end
      end
      ixh_pkg::S_DOWN: begin
        state_d = has_child ? ixh_pkg::S_DN_CMP : ixh_pkg::S_WRITE;
      end
      ixh_pkg::S_DN_CMP: begin
        state_d = (child.value > val_q) ? ixh_pkg::S_DOWN : ixh_pkg::S_WRITE;
      end
      ixh_pkg::S_WRITE: begin
        state_d = ixh_pkg::S_RD_ROOT;
      end
      ixh_pkg::S_RD_ROOT: begin
        state_d = ixh_pkg::S_FIN;
      end
      ixh_pkg::S_FIN: begin
        if (res_ready_i) begin
          state_d = ixh_pkg::S_IDLE;
        end
      end
      default: state_d = ixh_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    val_d      = val_q;
    rem_d      = rem_q;
    lab_d      = lab_q;
    h_d        = h_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    down_d     = down_q;
    moved_d    = moved_q;
    pres_we    = 1'b0;
    pres_val   = 1'b0;
    pres_addr  = lab_q;
    pos_we     = 1'b0;
    pos_waddr  = lab_q;
    pos_wdata  = h_q;
    slot_we    = 1'b0;
    slot_waddr = h_q;
    slot_wdata = '{value: val_q, label: lab_q};
    raddr_a    = IW'(1);
    raddr_b    = IW'(1);
    in_ready_o  = state_q == ixh_pkg::S_IDLE;
    res_valid_o = state_q == ixh_pkg::S_FIN;
    res_o.max_value     = (cnt_q == '0) ? '0 : rd_a.value;
    res_o.max_label     = (cnt_q == '0) ? '0 : rd_a.label;
    res_o.removed_value = rem_q;
    res_o.is_empty      = cnt_q == '0;
    res_o.is_full       = cnt_q == IW'(Capacity);
    res_o.status        = status_q;
    case (state_q)
      ixh_pkg::S_IDLE: begin
        pres_addr = in_i.label;
        if (accept) begin
          val_d    = in_i.value;
          lab_d    = in_i.label;
          rem_d    = '0;
          status_d = ixh_pkg::StOk;
          moved_d  = 1'b0;
          down_d   = in_i.op == ixh_pkg::OpInsert;
          if (!lab_ok) begin
            status_d = ixh_pkg::StAbsent;
          end else if (!lab_present) begin
            if (in_i.op == ixh_pkg::OpRemove) begin
              status_d = ixh_pkg::StAbsent;
            end else if (cnt_q == IW'(Capacity)) begin
              status_d = ixh_pkg::StFull;
            end else begin
              cnt_d    = cnt_q + IW'(1);
              h_d      = cnt_q + IW'(1);
              down_d   = 1'b0;
              pres_we  = 1'b1;
              pres_val = 1'b1;
            end
          end
        end
      end
      ixh_pkg::S_POS: begin
        h_d     = pos_rd_q;
        raddr_a = pos_rd_q;
        raddr_b = cnt_q;
      end
      ixh_pkg::S_RM: begin
        rem_d    = rd_a.value;
        pres_we  = 1'b1;
        pres_val = 1'b0;
        cnt_d    = cnt_q - IW'(1);
        val_d    = rd_b.value;
        lab_d    = rd_b.label;
        down_d   = 1'b1;
      end
      ixh_pkg::S_UP: begin
        raddr_a = h_q >> 1;
      end
      ixh_pkg::S_UP_CMP: begin
        if (val_q > rd_a.value) begin
          slot_we    = 1'b1;
          slot_wdata = rd_a;
          pos_we     = 1'b1;
          pos_waddr  = rd_a.label;
          h_d        = h_q >> 1;
          moved_d    = 1'b1;
        end
      end
      ixh_pkg::S_DOWN: begin
        raddr_a = child_l[IW-1:0];
        raddr_b = child_r[IW-1:0];
      end
      ixh_pkg::S_DN_CMP: begin
        if (child.value > val_q) begin
          slot_we    = 1'b1;
          slot_wdata = child;
          pos_we     = 1'b1;
          pos_waddr  = child.label;
          h_d        = child_idx;
        end
      end
      ixh_pkg::S_WRITE: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ixh_pkg::S_IDLE;
      cnt_q    <= '0;
      status_q <= ixh_pkg::StOk;
      down_q   <= 1'b0;
      moved_q  <= 1'b0;
      for (int i = 0; i < ixh_pkg::LabelCount; i++) begin
        present_q[i] <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      down_q   <= down_d;
      moved_q  <= moved_d;
      if (pres_we) begin
        present_q[pres_addr] <= pres_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    lab_q <= lab_d;
    h_q   <= h_d;
  end

endmodule

// ===== sv/indexed_max_heap.sv =====
// Indexed binary max-heap top level with registered result output.
//
//   channel | valid / ready             | payload
//   --------+---------------------------+-----------------------------
//   in      | in_valid_i / in_ready_o   | in_i  (op, value, label)
//   out     | out_valid_o / out_ready_i | out_o (max, removed, flags)
//
// A new label climbs through S_UP and S_UP_CMP for each level it rises, then
// S_WRITE, S_RD_ROOT and S_FIN; an update adds S_POS and a removal S_POS and
// S_RM for the position lookup, and sinking walks S_DOWN and S_DN_CMP per level.
// Reset clears the label-present bits and entry count at once.
// A result waits in the output register; the next item is taken meanwhile,
// and its result holds the input until the register empties.
`timescale 1ns / 1ps
module indexed_max_heap #(
  parameter int CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ixh_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ixh_pkg::out_t out_o
);

  logic          res_valid;
  logic          res_ready;
  ixh_pkg::out_t res;
  logic          out_valid_q;
  ixh_pkg::out_t out_q;

  ixh_ctrl #(
    .Capacity(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== dv/ixh_checker.sv =====
// Checker for the indexed max-heap: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module ixh_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ixh_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ixh_pkg::out_t out_i,
  output int            fail_cnt_o,
  output int            pending_o
);

  localparam int Cap = 64;

  logic signed [ixh_pkg::ValueW-1:0] hv [Cap+1];
  logic [ixh_pkg::LabelW-1:0]        hl [Cap+1];
  int                                lpos [ixh_pkg::LabelCount];
  bit                                lpres [ixh_pkg::LabelCount];
  int                                count;
  ixh_pkg::out_t                     expected_q [$];

  assign pending_o = expected_q.size();

  function automatic void put_slot(int idx, logic signed [ixh_pkg::ValueW-1:0] v,
                                   logic [ixh_pkg::LabelW-1:0] l);
    hv[idx] = v;
    hl[idx] = l;
    lpos[l] = idx;
  endfunction

  function automatic int sift_up(int h);
    logic signed [ixh_pkg::ValueW-1:0] v;
    logic [ixh_pkg::LabelW-1:0]        l;
    v = hv[h];
    l = hl[h];
    while (h > 1 && v > hv[h/2]) begin
      put_slot(h, hv[h/2], hl[h/2]);
      h = h / 2;
    end
    put_slot(h, v, l);
    return h;
  endfunction

  function automatic void sift_down(int h);
    logic signed [ixh_pkg::ValueW-1:0] v;
    logic [ixh_pkg::LabelW-1:0]        l;
    int                                c;
    v = hv[h];
    l = hl[h];
    while (h * 2 <= count) begin
      c = h * 2;
      if (c != count && hv[c+1] > hv[c]) c++;
      if (!(hv[c] > v)) break;
      put_slot(h, hv[c], hl[c]);
      h = c;
    end
    put_slot(h, v, l);
  endfunction

  function automatic void resettle(int h);
    if (sift_up(h) == h) sift_down(h);
  endfunction

  function automatic ixh_pkg::out_t heap_apply(ixh_pkg::in_t it);
    ixh_pkg::out_t r;
    int            pos;
    int            lab;
    r = '0;
    lab = it.label;
    r.status = ixh_pkg::StOk;
    if (lab >= ixh_pkg::LabelCount) begin
      r.status = ixh_pkg::StAbsent;
    end else if (it.op == ixh_pkg::OpInsert) begin
      if (lpres[lab]) begin
        hv[lpos[lab]] = it.value;
        resettle(lpos[lab]);
      end else if (count >= Cap) begin
        r.status = ixh_pkg::StFull;
      end else begin
        count++;
        put_slot(count, it.value, it.label);
        lpres[lab] = 1;
        void'(sift_up(count));
      end
    end else if (!lpres[lab]) begin
      r.status = ixh_pkg::StAbsent;
    end else begin
      pos = lpos[lab];
      r.removed_value = hv[pos];
      lpres[lab] = 0;
      count--;
      if (pos != count + 1) begin
        put_slot(pos, hv[count+1], hl[count+1]);
        resettle(pos);
      end
    end
    r.max_value = count ? hv[1] : '0;
    r.max_label = count ? hl[1] : '0;
    r.is_empty  = (count == 0);
    r.is_full   = (count >= Cap);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ixh_pkg::out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < ixh_pkg::LabelCount; i++) lpres[i] = 0;
      count = 0;
      fail_cnt_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(heap_apply(in_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: %p", out_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_i !== e) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (out_i.max_value !== e.max_value)
              $error("max_value exp %0d got %0d", e.max_value, out_i.max_value);
            if (out_i.max_label !== e.max_label)
              $error("max_label exp %0d got %0d", e.max_label, out_i.max_label);
            if (out_i.removed_value !== e.removed_value)
              $error("removed_value exp %0d got %0d", e.removed_value, out_i.removed_value);
            if (out_i.is_empty !== e.is_empty)
              $error("is_empty exp %0d got %0d", e.is_empty, out_i.is_empty);
            if (out_i.is_full !== e.is_full)
              $error("is_full exp %0d got %0d", e.is_full, out_i.is_full);
            if (out_i.status !== e.status)
              $error("status exp %0d got %0d", e.status, out_i.status);
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the indexed max-heap: stimulus, idling phases, watchdog, verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int WdLimit = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  ixh_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  ixh_pkg::out_t out_o;
  int            fail_cnt;
  int            pending;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            idle_cnt;

  always #4 clk_i = ~clk_i;

  indexed_max_heap u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  ixh_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .in_i(in_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_i(out_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WdLimit) begin
      $display("indexed_max_heap: mismatch");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [ixh_pkg::ValueW-1:0] v,
                           logic [ixh_pkg::LabelW-1:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= '{op: op, value: v, label: l};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic signed [ixh_pkg::ValueW-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(7)) - 32'sd3);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int lab_max;
    idle_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(ixh_pkg::OpRemove, 0, 7'd5);
    send_item(ixh_pkg::OpInsert, 32'sh7fffffff, 7'd64);
    send_item(ixh_pkg::OpInsert, 32'sh80000000, 7'd0);
    send_item(ixh_pkg::OpInsert, 32'sd10, 7'd1);
    send_item(ixh_pkg::OpInsert, 32'sd10, 7'd2);
    send_item(ixh_pkg::OpInsert, -32'sd1, 7'd64);
    send_item(ixh_pkg::OpInsert, 32'sd5, 7'd65);
    send_item(ixh_pkg::OpRemove, 0, 7'd127);
    send_item(ixh_pkg::OpRemove, 0, 7'd2);
    send_item(ixh_pkg::OpRemove, 0, 7'd2);
    send_item(ixh_pkg::OpRemove, 0, 7'd64);
    send_item(ixh_pkg::OpRemove, 0, 7'd1);
    send_item(ixh_pkg::OpRemove, 0, 7'd0);
    for (int i = 0; i <= 64; i++) send_item(ixh_pkg::OpInsert, rand_value(), 7'(i));
    send_item(ixh_pkg::OpInsert, 32'sh7fffffff, 7'd30);
    send_item(ixh_pkg::OpInsert, 32'sh80000000, 7'd0);
    drain();
    for (int n = 0; n < 420; n++) begin
      phase = n / 105;
      send_idle_pct  = (phase == 1 || phase == 3) ? 57 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3 ? 21 : 0);
      if (phase == 3) send_idle_pct = 21;
      if (n == 210) drain();
      lab_max = (n % 105 < 45) ? 15 : 64;
      if ($urandom_range(19) == 0)
        send_item(1'($urandom_range(1)), rand_value(), 7'($urandom_range(127)));
      else
        send_item($urandom_range(99) < 45, rand_value(), 7'($urandom_range(lab_max)));
    end
    drain();
    if (fail_cnt == 0) $display("indexed_max_heap: match");
    else $display("indexed_max_heap: mismatch");
    $finish;
  end
endmodule
